### src/assert_macros.svh
// assertion helper macros for the tokenizer rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KOT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define KOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define KOT_ASSERT_ALWAYS(label, clk, rst_n, expr)

`define KOT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/kot_pkg.sv
// types, character and token codes, and lookup functions for the tokenizer
// no dependencies; used by keyword_operator_tokenizer_top
`default_nettype none

package kot_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int NUM_KW = 6;
    localparam int KW_MAX = 5;
    localparam int FIFO_DEPTH = 4;

    // token codes
    localparam logic [4:0] TOK_HASH     = 5'd0;
    localparam logic [4:0] TOK_IDENT    = 5'd10;
    localparam logic [4:0] TOK_NUMBER   = 5'd11;
    localparam logic [4:0] TOK_PLUS     = 5'd13;
    localparam logic [4:0] TOK_MINUS    = 5'd14;
    localparam logic [4:0] TOK_STAR     = 5'd15;
    localparam logic [4:0] TOK_SLASH    = 5'd16;
    localparam logic [4:0] TOK_COLON    = 5'd17;
    localparam logic [4:0] TOK_ASSIGN   = 5'd18;
    localparam logic [4:0] TOK_LT       = 5'd20;
    localparam logic [4:0] TOK_NE       = 5'd21;
    localparam logic [4:0] TOK_LE       = 5'd22;
    localparam logic [4:0] TOK_GT       = 5'd23;
    localparam logic [4:0] TOK_GE       = 5'd24;
    localparam logic [4:0] TOK_EQ       = 5'd25;
    localparam logic [4:0] TOK_SEMI     = 5'd26;
    localparam logic [4:0] TOK_LPAREN   = 5'd27;
    localparam logic [4:0] TOK_RPAREN   = 5'd28;
    localparam logic [4:0] TOK_BAD_NUM  = 5'd29;
    localparam logic [4:0] TOK_ILLEGAL  = 5'd30;

    // characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_HASH   = 8'h23;

    typedef enum logic [4:0] {
        KIND_NONE  = 5'b00001,
        KIND_IDENT = 5'b00010,
        KIND_NUM   = 5'b00100,
        KIND_BAD   = 5'b01000,
        KIND_OP    = 5'b10000
    } kind_t;

    typedef struct packed {
        logic        last;
        logic        ovf;
        logic [31:0] value;
        logic [7:0]  len;
        logic [4:0]  code;
    } tok_t;

    typedef logic [7:0] kw_row_t [KW_MAX];

    localparam kw_row_t KW_TEXT [NUM_KW] = '{
        '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6E},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
        '{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},
        '{8'h64, 8'h6F, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00}
    };
    localparam logic [7:0] KW_LEN [NUM_KW] = '{8'd5, 8'd2, 8'd4, 8'd5, 8'd2, 8'd3};

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hold_op(input logic [7:0] c);
        return c == CH_COLON || c == CH_LT || c == CH_GT;
    endfunction

    // narrow the keyword candidates by one more character at position p
    function automatic logic [NUM_KW-1:0] kw_step(input logic [NUM_KW-1:0] mask,
                                                 input logic [7:0] p,
                                                 input logic [7:0] c);
        logic [NUM_KW-1:0] m;
        m = mask;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (p >= KW_LEN[k])
                m[k] = 1'b0;
            else if (KW_TEXT[k][p[2:0]] != c)
                m[k] = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [4:0] kw_code(input logic [NUM_KW-1:0] mask,
                                           input logic [7:0] len);
        logic [4:0] code;
        code = TOK_IDENT;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (mask[k] && len == KW_LEN[k])
                code = 5'(k + 1);
        end
        return code;
    endfunction

    function automatic logic [4:0] held_code(input logic [7:0] h);
        logic [4:0] code;
        unique case (h)
            CH_COLON: code = TOK_COLON;
            CH_LT:    code = TOK_LT;
            CH_GT:    code = TOK_GT;
            default:  code = TOK_ILLEGAL;
        endcase
        return code;
    endfunction

    function automatic logic [4:0] pair_code(input logic [7:0] h);
        logic [4:0] code;
        unique case (h)
            CH_COLON: code = TOK_ASSIGN;
            CH_LT:    code = TOK_LE;
            default:  code = TOK_GE;
        endcase
        return code;
    endfunction

    function automatic logic [4:0] single_code(input logic [7:0] c);
        logic [4:0] code;
        unique case (c)
            CH_PLUS:   code = TOK_PLUS;
            CH_MINUS:  code = TOK_MINUS;
            CH_STAR:   code = TOK_STAR;
            CH_SLASH:  code = TOK_SLASH;
            CH_EQ:     code = TOK_EQ;
            CH_SEMI:   code = TOK_SEMI;
            CH_LPAREN: code = TOK_LPAREN;
            CH_RPAREN: code = TOK_RPAREN;
            CH_HASH:   code = TOK_HASH;
            default:   code = TOK_ILLEGAL;
        endcase
        return code;
    endfunction

    function automatic logic [4:0] flush_code(input kind_t kind,
                                              input logic [NUM_KW-1:0] mask,
                                              input logic [7:0] len,
                                              input logic [7:0] h);
        logic [4:0] code;
        unique case (kind)
            KIND_IDENT: code = kw_code(mask, len);
            KIND_NUM:   code = TOK_NUMBER;
            KIND_BAD:   code = TOK_BAD_NUM;
            KIND_OP:    code = held_code(h);
            default:    code = TOK_ILLEGAL;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] len_inc(input logic [7:0] len);
        return (len == 8'hFF) ? len : len + 8'd1;
    endfunction

endpackage

`default_nettype wire

### src/keyword_operator_tokenizer_top.sv
// character stream tokenizer: keywords, identifiers, numbers and operators
// depends on kot_pkg and assert_macros.svh
`default_nettype none

// Takes one character per beat and emits classified tokens. A character is
// accepted every clock while the four-entry token queue has room for two
// tokens; classification, keyword narrowing and the decimal multiply-add are
// done in the same cycle as the accept and tokens go into the output queue.
// A character that both ends a pending token and forms a token of its own
// yields two output beats, so the output side sets the sustained rate when
// many characters produce two tokens. No clearing pass after reset.
`include "assert_macros.svh"

module keyword_operator_tokenizer_top #(
    parameter int VALUE_BITS = kot_pkg::DEF_VALUE_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_in
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // token_code, token_length, number_value,
                                             // value_overflow, zero pad
    output logic             m_axis_tlast    // last_result
);
    import kot_pkg::*;

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // pending token state
    kind_t                 kind_reg, kind_next;
    logic [7:0]            len_reg, len_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;
    logic [NUM_KW-1:0]     mask_reg, mask_next;
    logic [7:0]            held_reg, held_next;

    // token queue
    tok_t                  fifo_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    logic                  accept, pop;
    logic [7:0]            c;
    logic [3:0]            digit;
    logic [VALUE_BITS+3:0] acc_ext, prod;
    logic                  run_fresh;
    logic                  a_v, b_v, c_v;
    tok_t                  a_t, b_t, c_t, res0, res1;
    logic [1:0]            push_n;

    function automatic logic [31:0] low_word(input logic [VALUE_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));
    assign c             = s_axis_tdata;
    assign digit         = c[3:0];

    // value * 10 + digit, with room for the carry out
    assign acc_ext = {4'b0000, acc_reg};
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_BITS{1'b0}}, digit};

    always_comb
    begin
        kind_next = kind_reg;
        len_next  = len_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        mask_next = mask_reg;
        held_next = held_reg;
        run_fresh = 1'b0;
        a_v       = 1'b0;
        b_v       = 1'b0;
        c_v       = 1'b0;

        a_t       = '0;
        a_t.code  = flush_code(kind_reg, mask_reg, len_reg, held_reg);
        a_t.len   = len_reg;
        a_t.value = (kind_reg == KIND_NUM) ? low_word(acc_reg) : 32'd0;
        a_t.ovf   = (kind_reg == KIND_NUM) ? ovf_reg : 1'b0;

        b_t       = '0;
        b_t.code  = single_code(c);
        b_t.len   = 8'd1;

        unique case (kind_reg)
            KIND_OP:
            begin
                a_v = 1'b1;
                if (c == CH_EQ)
                begin
                    a_t.code = pair_code(held_reg);
                    a_t.len  = 8'd2;
                end
                else if (held_reg == CH_LT && c == CH_GT)
                begin
                    a_t.code = TOK_NE;
                    a_t.len  = 8'd2;
                end
                else
                begin
                    run_fresh = 1'b1;
                end
            end
            KIND_IDENT:
            begin
                if (is_letter(c) || is_digit(c))
                begin
                    mask_next = kw_step(mask_reg, len_reg, c);
                    len_next  = len_inc(len_reg);
                end
                else
                begin
                    a_v       = 1'b1;
                    run_fresh = 1'b1;
                end
            end
            KIND_BAD:
            begin
                if (is_letter(c) || is_digit(c))
                    len_next = len_inc(len_reg);
                else
                begin
                    a_v       = 1'b1;
                    run_fresh = 1'b1;
                end
            end
            KIND_NUM:
            begin
                if (is_digit(c))
                begin
                    if (|prod[VALUE_BITS+3:VALUE_BITS])
                    begin
                        acc_next = '1;
                        ovf_next = 1'b1;
                    end
                    else
                        acc_next = prod[VALUE_BITS-1:0];
                    len_next = len_inc(len_reg);
                end
                else if (is_letter(c))
                begin
                    kind_next = KIND_BAD;
                    acc_next  = '0;
                    ovf_next  = 1'b0;
                    len_next  = len_inc(len_reg);
                end
                else
                begin
                    a_v       = 1'b1;
                    run_fresh = 1'b1;
                end
            end
            default:
            begin
                run_fresh = 1'b1;
            end
        endcase

        // token emitted or new token begins: start from a clear state
        if (a_v || run_fresh)
        begin
            kind_next = KIND_NONE;
            len_next  = 8'd0;
            acc_next  = '0;
            ovf_next  = 1'b0;
            mask_next = '1;
            held_next = 8'd0;
        end

        if (run_fresh && c != CH_SPACE)
        begin
            if (is_letter(c))
            begin
                kind_next = KIND_IDENT;
                mask_next = kw_step('1, 8'd0, c);
                len_next  = 8'd1;
            end
            else if (is_digit(c))
            begin
                kind_next = KIND_NUM;
                acc_next  = {{(VALUE_BITS-4){1'b0}}, digit};
                len_next  = 8'd1;
            end
            else if (is_hold_op(c))
            begin
                kind_next = KIND_OP;
                held_next = c;
                len_next  = 8'd1;
            end
            else
                b_v = 1'b1;
        end

        // end of input flushes whatever is left
        c_t       = '0;
        c_t.code  = flush_code(kind_next, mask_next, len_next, held_next);
        c_t.len   = len_next;
        c_t.value = (kind_next == KIND_NUM) ? low_word(acc_next) : 32'd0;
        c_t.ovf   = (kind_next == KIND_NUM) ? ovf_next : 1'b0;
        if (s_axis_tlast)
        begin
            c_v       = (kind_next != KIND_NONE);
            kind_next = KIND_NONE;
            len_next  = 8'd0;
            acc_next  = '0;
            ovf_next  = 1'b0;
            mask_next = '1;
            held_next = 8'd0;
        end
    end

    // order the up to two tokens of this beat
    always_comb
    begin
        push_n = accept ? (2'(a_v) + 2'(b_v) + 2'(c_v)) : 2'd0;
        if (a_v)
            res0 = a_t;
        else if (b_v)
            res0 = b_t;
        else
            res0 = c_t;
        res1      = (a_v && b_v) ? b_t : c_t;
        res0.last = (push_n == 2'd1);
        res1.last = 1'b1;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push_n) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_NONE;
            len_reg    <= 8'd0;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            mask_reg   <= '1;
            held_reg   <= 8'd0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                kind_reg <= kind_next;
                len_reg  <= len_next;
                acc_reg  <= acc_next;
                ovf_reg  <= ovf_next;
                mask_reg <= mask_next;
                held_reg <= held_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_mem[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_mem[wr_ptr_reg + PTR_BITS'(1)] <= res1;
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {2'b00, fifo_mem[rd_ptr_reg].ovf, fifo_mem[rd_ptr_reg].value,
                            fifo_mem[rd_ptr_reg].len, fifo_mem[rd_ptr_reg].code};
    assign m_axis_tlast  = fifo_mem[rd_ptr_reg].last;

    `KOT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_BITS'(FIFO_DEPTH))
    `KOT_ASSERT_ALWAYS(a_ovf_only_num, clk, rst_n, !ovf_reg || kind_reg == KIND_NUM)
    `KOT_ASSERT_ALWAYS(a_held_only_op, clk, rst_n, kind_reg == KIND_OP || held_reg == 8'd0)
    `KOT_ASSERT_NEXT(a_flush_on_last, clk, rst_n, accept && s_axis_tlast, kind_reg == KIND_NONE)

endmodule

`default_nettype wire
